// ----- design/lse_pkg.sv -----
// Package for the Legendre series evaluator: shared types, state codes and widths.
// Holds the saturation helper used by the datapath; depends on nothing else.
`default_nettype none
package lse_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int DIV_CNT_W = 6;
  localparam int DOM_BITS  = 62;
  localparam int STEP_BITS = 42;

  localparam logic [CFG_IDX_W-1:0] REG_TERM_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_LOW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_HIGH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH     = 3'd4;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SAT   = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_DIV  = 11'b00000000010,
    S_TMAP = 11'b00000000100,
    S_MUL  = 11'b00000001000,
    S_NUM  = 11'b00000010000,
    S_STEP = 11'b00000100000,
    S_SUM  = 11'b00001000000,
    S_Y1   = 11'b00010000000,
    S_Y2   = 11'b00100000000,
    S_Y3   = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [69:0] v);
    sat_t r;
    if (v > 70'sd2147483647) begin
      r.sat = 1'b1;
      r.val = 32'sh7fffffff;
    end else if (v < -70'sd2147483648) begin
      r.sat = 1'b1;
      r.val = 32'sh80000000;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/legendre_series_evaluator_top.sv -----
// Legendre series evaluator, Clenshaw recurrence over one shared multiplier and divider.
// A load writes its coefficient and valid bit and stays idle. An evaluate uses the
// radix-2 divider (62 bits for the domain map, 42 per recurrence step) before out_valid
// rises; a result waits in S_OUT until an earlier one is taken. An empty domain answers
// with status EMPTY and no division. One item is in work at a time.
// Synchronous reset clears the coefficient valid bits and loads the register defaults.
`default_nettype none
module legendre_series_evaluator_top #(
  parameter int MAX_TERMS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           func,
  input  wire logic [3:0]                     coef_index,
  input  wire logic signed [31:0]             value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [31:0]                  y_value,
  output logic [1:0]                          status,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                    cfg_data
);

  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int KW    = $clog2(MAX_TERMS + 1);

  lse_pkg::state_t state;

  logic [4:0]         term_count;
  logic signed [31:0] x_low, x_high, y_low, y_high;

  logic [31:0]          mem [MAX_TERMS];
  logic [MAX_TERMS-1:0] vld;
  logic [31:0]          rd_data;
  logic                 rd_vld;
  logic [IDX_W-1:0]     rd_addr;

  logic [KW-1:0]        k;
  logic signed [31:0]   t, q0, q1;
  logic signed [32:0]   r1;
  logic                 sat_flag;
  logic                 dom_div;

  logic signed [33:0]   mul_a, mul_b;
  logic signed [67:0]   prod, acc;

  logic [31:0]          den;
  logic [31:0]          rem;
  logic [63:0]          quo;
  logic                 neg;
  logic [lse_pkg::DIV_CNT_W-1:0] cnt;

  logic signed [31:0]   y_res;
  logic [1:0]           st_res;

  logic signed [32:0]   dx, dy, xd;
  logic [32:0]          xd_mag;
  logic signed [31:0]   coef;
  lse_pkg::sat_t        c28, qsat, tsat, ssat, ysat;
  logic signed [39:0]   m;
  logic signed [43:0]   num;
  logic [43:0]          num_mag;
  logic signed [69:0]   qs, yw;
  logic [32:0]          dsh;
  logic [33:0]          ddiff;
  logic [KW-1:0]        k_start;
  int                   n_eff;

  assign in_ready  = (state == lse_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    dx      = 33'(x_high) - 33'(x_low);
    dy      = 33'(y_high) - 33'(y_low);
    xd      = 33'(value) - 33'(x_low);
    xd_mag  = xd[32] ? 33'(-xd) : 33'(xd);
    coef    = rd_vld ? signed'(rd_data) : 32'sd0;
    c28     = lse_pkg::sat32(70'(coef) <<< 12);
    m       = 40'((70'(prod) + (70'sd1 <<< 27)) >>> 28);
    num     = 44'(signed'({1'b0, k, 1'b1})) * 44'(m)
            - 44'(signed'({1'b0, k} + (KW+1)'(1))) * 44'(q1)
            - 44'(c28.val);
    num_mag = num[43] ? 44'(-num) : 44'(num);
    qs      = neg ? -70'(signed'({1'b0, quo})) : 70'(signed'({1'b0, quo}));
    qsat    = lse_pkg::sat32(qs);
    tsat    = lse_pkg::sat32(qs - (70'sd1 <<< 28));
    ssat    = lse_pkg::sat32(70'(c28.val) + 70'(q1) - 70'(m));
    yw      = (((70'(acc) <<< 16) + 70'(prod) + (70'sd1 <<< 28)) >>> 29) + 70'(y_low);
    ysat    = lse_pkg::sat32(yw);
    dsh     = {rem, quo[63]};
    ddiff   = {1'b0, dsh} - {2'b0, den};
    if (term_count == 5'd0) begin
      n_eff = 1;
    end else if (int'(term_count) > MAX_TERMS) begin
      n_eff = MAX_TERMS;
    end else begin
      n_eff = int'(term_count);
    end
    k_start = KW'(n_eff - 1);
    rd_addr = k[IDX_W-1:0];
  end

  always_comb begin
    mul_a = 34'(t);
    mul_b = 34'(q0);
    if (state == lse_pkg::S_Y1) begin
      mul_a = 34'(r1 >>> 16);
      mul_b = 34'(dy);
    end else if (state == lse_pkg::S_Y2) begin
      mul_a = signed'({18'b0, r1[15:0]});
      mul_b = 34'(dy);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && func == lse_pkg::FUNC_LOAD && int'(coef_index) < MAX_TERMS) begin
      mem[IDX_W'(coef_index)] <= value;
    end
    rd_data <= mem[rd_addr];
    rd_vld  <= vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lse_pkg::S_IDLE;
      vld        <= '0;
      out_valid  <= 1'b0;
      term_count <= 5'd1;
      x_low      <= -32'sd65536;
      x_high     <= 32'sd65536;
      y_low      <= -32'sd65536;
      y_high     <= 32'sd65536;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lse_pkg::REG_TERM_COUNT: term_count <= cfg_data[4:0];
          lse_pkg::REG_X_LOW:      x_low      <= cfg_data;
          lse_pkg::REG_X_HIGH:     x_high     <= cfg_data;
          lse_pkg::REG_Y_LOW:      y_low      <= cfg_data;
          lse_pkg::REG_Y_HIGH:     y_high     <= cfg_data;
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready && state != lse_pkg::S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        lse_pkg::S_IDLE: begin
          if (in_valid) begin
            if (func == lse_pkg::FUNC_LOAD) begin
              if (int'(coef_index) < MAX_TERMS) begin
                vld[IDX_W'(coef_index)] <= 1'b1;
              end
            end else if (dx == 33'sd0) begin
              y_res  <= 32'sd0;
              st_res <= lse_pkg::STATUS_EMPTY;
              state  <= lse_pkg::S_OUT;
            end else begin
              sat_flag <= 1'b0;
              dom_div  <= 1'b1;
              neg      <= xd[32] ^ dx[32];
              den      <= dx[32] ? 32'(-dx) : 32'(dx);
              rem      <= '0;
              quo      <= {xd_mag, 31'b0};
              cnt      <= lse_pkg::DIV_CNT_W'(lse_pkg::DOM_BITS - 1);
              state    <= lse_pkg::S_DIV;
            end
          end
        end
        lse_pkg::S_DIV: begin
          if (!ddiff[33]) begin
            rem <= ddiff[31:0];
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= dsh[31:0];
            quo <= {quo[62:0], 1'b0};
          end
          if (cnt == '0) begin
            state <= dom_div ? lse_pkg::S_TMAP : lse_pkg::S_STEP;
          end else begin
            cnt <= cnt - lse_pkg::DIV_CNT_W'(1);
          end
        end
        lse_pkg::S_TMAP: begin
          t        <= tsat.val;
          sat_flag <= sat_flag | tsat.sat;
          q0       <= '0;
          q1       <= '0;
          k        <= k_start;
          state    <= lse_pkg::S_MUL;
        end
        lse_pkg::S_MUL: begin
          state <= (k == '0) ? lse_pkg::S_SUM : lse_pkg::S_NUM;
        end
        lse_pkg::S_NUM: begin
          sat_flag <= sat_flag | c28.sat;
          dom_div  <= 1'b0;
          neg      <= num[43];
          den      <= 32'(k);
          rem      <= '0;
          quo      <= {num_mag[lse_pkg::STEP_BITS-1:0], 22'b0};
          cnt      <= lse_pkg::DIV_CNT_W'(lse_pkg::STEP_BITS - 1);
          state    <= lse_pkg::S_DIV;
        end
        lse_pkg::S_STEP: begin
          sat_flag <= sat_flag | qsat.sat;
          q1       <= q0;
          q0       <= qsat.val;
          k        <= k - KW'(1);
          state    <= lse_pkg::S_MUL;
        end
        lse_pkg::S_SUM: begin
          sat_flag <= sat_flag | c28.sat | ssat.sat;
          r1       <= 33'(ssat.val) + (33'sd1 <<< 28);
          state    <= lse_pkg::S_Y1;
        end
        lse_pkg::S_Y1: begin
          state <= lse_pkg::S_Y2;
        end
        lse_pkg::S_Y2: begin
          state <= lse_pkg::S_Y3;
        end
        lse_pkg::S_Y3: begin
          y_res  <= ysat.val;
          st_res <= (sat_flag | ysat.sat) ? lse_pkg::STATUS_SAT : lse_pkg::STATUS_OK;
          state  <= lse_pkg::S_OUT;
        end
        lse_pkg::S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            y_value   <= y_res;
            status    <= st_res;
            state     <= lse_pkg::S_IDLE;
          end
        end
        default: state <= lse_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (state == lse_pkg::S_Y2) begin
      acc <= prod;
    end
  end

endmodule
`default_nettype wire
